[rtl/lsra_pkg.sv]
package lsra_pkg;

	localparam int IDX_W      = 5;
	localparam int END_W      = 17;
	localparam int ID_W       = 16;
	localparam int POS_W      = 16;
	localparam int NUM_W      = 5;
	localparam int BASE_W     = 4;
	localparam int CNT_W      = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [BASE_W-1:0] BASE_RESET  = 4'd4;
	localparam logic [CNT_W-1:0]  COUNT_RESET = 5'd7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE  = 1'b0,
		REG_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// scan wave handed from cell to cell
	typedef struct packed {
		logic                    tok;
		logic                    found;
		logic [IDX_W-1:0]        free_idx;
		logic                    has_best;
		logic signed [END_W-1:0] best_end;
		logic [IDX_W-1:0]        best_idx;
		logic [ID_W-1:0]         best_tag;
	} carry_t;

	// slot write broadcast after the decision
	typedef struct packed {
		logic                    en;
		logic [IDX_W-1:0]        idx;
		logic signed [END_W-1:0] end_pos;
		logic [ID_W-1:0]         tag;
	} wr_t;

endpackage

[rtl/lsra_in_if.sv]
interface lsra_in_if;
	logic                                    valid;
	logic                                    ready;
	logic                                    first_of_pass;
	logic [lsra_pkg::ID_W-1:0]               interval_id;
	logic [lsra_pkg::POS_W-1:0]              interval_start;
	logic signed [lsra_pkg::END_W-1:0]       interval_end;

	modport source (
		output valid, first_of_pass, interval_id, interval_start, interval_end,
		input  ready
	);
	modport sink (
		input  valid, first_of_pass, interval_id, interval_start, interval_end,
		output ready
	);
endinterface

[rtl/lsra_out_if.sv]
interface lsra_out_if;
	logic                          valid;
	logic                          ready;
	logic                          got_register;
	logic [lsra_pkg::NUM_W-1:0]    register_number;
	logic                          evicted_valid;
	logic [lsra_pkg::ID_W-1:0]     evicted_id;

	modport source (
		output valid, got_register, register_number, evicted_valid, evicted_id,
		input  ready
	);
	modport sink (
		input  valid, got_register, register_number, evicted_valid, evicted_id,
		output ready
	);
endinterface

[rtl/lsra_cell.sv]
module lsra_cell #(
	parameter int IDX = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              clear,
	input  logic [lsra_pkg::CNT_W-1:0]        pool_count,
	input  logic [lsra_pkg::POS_W-1:0]        start,
	input  lsra_pkg::wr_t                     wr,
	input  lsra_pkg::carry_t                  carry_in,
	output lsra_pkg::carry_t                  carry_out
);

	localparam logic [lsra_pkg::IDX_W-1:0] MY_IDX = lsra_pkg::IDX_W'(IDX);

	logic                                valid_q;
	logic signed [lsra_pkg::END_W-1:0]   end_q;
	logic [lsra_pkg::ID_W-1:0]           tag_q;
	logic                                expired;
	logic                                valid_after;
	logic                                in_pool;
	logic                                is_free;
	logic                                take_best;
	logic                                wr_hit;
	lsra_pkg::carry_t                    carry_d;

	assign expired     = end_q < $signed({1'b0, start});
	assign valid_after = valid_q && !expired;
	assign in_pool     = {1'b0, MY_IDX} < {1'b0, pool_count};
	assign is_free     = in_pool && !valid_after;
	assign take_best   = valid_after &&
		(!carry_in.has_best || (end_q >= $signed(carry_in.best_end)));
	assign wr_hit      = wr.en && (wr.idx == MY_IDX);

	always_comb begin
		carry_d = carry_in;
		if (!carry_in.found && is_free) begin
			carry_d.found    = 1'b1;
			carry_d.free_idx = MY_IDX;
		end
		if (take_best) begin
			carry_d.has_best = 1'b1;
			carry_d.best_end = end_q;
			carry_d.best_idx = MY_IDX;
			carry_d.best_tag = tag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			carry_out <= '0;
		end else begin
			carry_out <= carry_d;
			if (clear) begin
				valid_q <= 1'b0;
			end else if (wr_hit) begin
				valid_q <= 1'b1;
			end else if (carry_in.tok) begin
				valid_q <= valid_after;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			end_q <= wr.end_pos;
			tag_q <= wr.tag;
		end
	end

endmodule

[rtl/linear_scan_register_allocator.sv]
// Linear-scan register allocator. Live intervals enter in increasing start
// order, one at a time; each yields one word: whether it got a register, the
// machine register number (base_register plus pool slot, mod 32), and the id of
// any active interval spilled to make room. Each pool slot is a cell in a
// chain of MAX_REGS cells. After an accept the expiry and search wave is
// launched and walks the cell chain, the finished wave is captured, then
// the decision is made and the slot written, and the block goes back to
// idle to take the next interval, so intervals are taken one at a time; the
// decision also waits while an earlier result word is still unaccepted. The
// result word sits in an output register, so the next interval can be
// accepted while it waits. Writing register_count clears the active set.
module linear_scan_register_allocator #(
	parameter int MAX_REGS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [lsra_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lsra_pkg::CFG_DATA_W-1:0]       cfg_data,
	lsra_in_if.sink                               intervals,
	lsra_out_if.source                            grants
);

	lsra_pkg::state_t                    state_q, state_d;
	logic [lsra_pkg::BASE_W-1:0]         base_q;
	logic [lsra_pkg::CNT_W-1:0]          count_q;
	logic [lsra_pkg::POS_W-1:0]          start_q;
	logic signed [lsra_pkg::END_W-1:0]   end_q;
	logic [lsra_pkg::ID_W-1:0]           id_q;
	logic                                launch_q;
	lsra_pkg::carry_t                    fin_q;
	logic                                out_valid_q;
	logic                                got_q;
	logic [lsra_pkg::NUM_W-1:0]          num_q;
	logic                                ev_q;
	logic [lsra_pkg::ID_W-1:0]           evid_q;

	logic                                accept;
	logic                                decide;
	logic                                clear_all;
	logic                                evict;
	logic                                grant;
	logic [lsra_pkg::IDX_W-1:0]          slot;
	lsra_pkg::wr_t                       wr;
	lsra_pkg::carry_t                    chain [MAX_REGS+1];

	assign accept    = intervals.valid && intervals.ready;
	assign clear_all = (accept && intervals.first_of_pass) ||
		(cfg_we && (cfg_index == lsra_pkg::REG_COUNT));

	always_comb begin
		chain[0]     = '0;
		chain[0].tok = launch_q;
	end

	for (genvar g = 0; g < MAX_REGS; g++) begin : g_cell
		lsra_cell #(.IDX(g)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.clear      (clear_all),
			.pool_count (count_q),
			.start      (start_q),
			.wr         (wr),
			.carry_in   (chain[g]),
			.carry_out  (chain[g+1])
		);
	end

	// decision on the finished wave
	assign evict = !fin_q.found && fin_q.has_best && ($signed(fin_q.best_end) > end_q);
	assign grant = fin_q.found || evict;
	assign slot  = fin_q.found ? fin_q.free_idx : fin_q.best_idx;

	always_comb begin
		wr.en      = decide && grant;
		wr.idx     = slot;
		wr.end_pos = end_q;
		wr.tag     = id_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lsra_pkg::ST_IDLE: if (accept) state_d = lsra_pkg::ST_SCAN;
			lsra_pkg::ST_SCAN: if (chain[MAX_REGS].tok) state_d = lsra_pkg::ST_DONE;
			lsra_pkg::ST_DONE: if (decide) state_d = lsra_pkg::ST_IDLE;
			default:           state_d = lsra_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		intervals.ready = 1'b0;
		decide          = 1'b0;
		unique case (state_q)
			lsra_pkg::ST_IDLE: intervals.ready = 1'b1;
			lsra_pkg::ST_SCAN: ;
			lsra_pkg::ST_DONE: decide = !out_valid_q || grants.ready;
			default:           ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lsra_pkg::ST_IDLE;
			base_q      <= lsra_pkg::BASE_RESET;
			count_q     <= lsra_pkg::COUNT_RESET;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= accept;
			if (cfg_we) begin
				unique case (cfg_index)
					lsra_pkg::REG_BASE:  base_q  <= cfg_data[lsra_pkg::BASE_W-1:0];
					lsra_pkg::REG_COUNT: count_q <= cfg_data;
					default: ;
				endcase
			end
			if (decide) begin
				out_valid_q <= 1'b1;
			end else if (grants.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= intervals.interval_start;
			end_q   <= intervals.interval_end;
			id_q    <= intervals.interval_id;
		end
		if (chain[MAX_REGS].tok) begin
			fin_q <= chain[MAX_REGS];
		end
		if (decide) begin
			got_q  <= grant;
			num_q  <= grant ? lsra_pkg::NUM_W'({1'b0, base_q} + slot) : '0;
			ev_q   <= evict;
			evid_q <= evict ? fin_q.best_tag : '0;
		end
	end

	assign grants.valid           = out_valid_q;
	assign grants.got_register    = got_q;
	assign grants.register_number = num_q;
	assign grants.evicted_valid   = ev_q;
	assign grants.evicted_id      = evid_q;

	a_launch_scan: assert property (@(posedge clk) disable iff (!arst_n)
		launch_q |-> state_q == lsra_pkg::ST_SCAN)
		else $error("scan wave launched outside scan state");

	a_decide_out: assert property (@(posedge clk) disable iff (!arst_n)
		decide |=> out_valid_q)
		else $error("decision did not load the result word");

	a_evict_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(decide && evict) |-> (grant && !fin_q.found))
		else $error("eviction without grant");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !intervals.ready)
		else $error("second interval taken during scan");

endmodule
